FILE: rtl/fly_camera_pose_update_defines.svh
// assertion macros for the fly camera pose update checker
// no dependencies
`ifndef FLY_CAMERA_POSE_UPDATE_DEFINES_SVH
`define FLY_CAMERA_POSE_UPDATE_DEFINES_SVH
// property that must hold on every clock edge outside reset
`define FCP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same, without disabling during reset
`define FCP_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: rtl/fcp_pkg.sv
// shared constants, types and helpers for the fly camera pose update
// no dependencies
`default_nettype none
package fcp_pkg;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int VEC_FRAC_BITS_DEF = 14;
	localparam int CORDIC_STEPS      = 30;
	localparam int CORDIC_GAIN_Q30   = 652032874;

	typedef struct packed {
		logic [15:0] pitch_delta;
		logic [15:0] yaw_delta;
		logic [31:0] move_right;
		logic [31:0] move_up;
		logic [31:0] move_forward;
	} in_req_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [15:0] fwd_x;
		logic [15:0] fwd_y;
		logic [15:0] fwd_z;
		logic [15:0] up_x;
		logic [15:0] up_y;
		logic [15:0] up_z;
		logic [15:0] right_x;
		logic [15:0] right_z;
	} out_req_t;

	// datapath commands
	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_LOAD   = 4'd1;
	localparam logic [3:0] OP_CINITP = 4'd2;
	localparam logic [3:0] OP_CSTEP  = 4'd3;
	localparam logic [3:0] OP_CENDP  = 4'd4;
	localparam logic [3:0] OP_CINITY = 4'd5;
	localparam logic [3:0] OP_CENDY  = 4'd6;
	localparam logic [3:0] OP_MUL    = 4'd7;
	localparam logic [3:0] OP_MACC   = 4'd8;

	typedef struct packed {
		logic [3:0] op;
		logic [4:0] step;
	} dp_cmd_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		case (i)
			5'd0: atan_turn = 32'd536870912;  5'd1: atan_turn = 32'd316933406;
			5'd2: atan_turn = 32'd167458907;  5'd3: atan_turn = 32'd85004756;
			5'd4: atan_turn = 32'd42667331;   5'd5: atan_turn = 32'd21354465;
			5'd6: atan_turn = 32'd10679838;   5'd7: atan_turn = 32'd5340245;
			5'd8: atan_turn = 32'd2670163;    5'd9: atan_turn = 32'd1335087;
			5'd10: atan_turn = 32'd667544;    5'd11: atan_turn = 32'd333772;
			5'd12: atan_turn = 32'd166886;    5'd13: atan_turn = 32'd83443;
			5'd14: atan_turn = 32'd41722;     5'd15: atan_turn = 32'd20861;
			5'd16: atan_turn = 32'd10430;     5'd17: atan_turn = 32'd5215;
			5'd18: atan_turn = 32'd2608;      5'd19: atan_turn = 32'd1304;
			5'd20: atan_turn = 32'd652;       5'd21: atan_turn = 32'd326;
			5'd22: atan_turn = 32'd163;       5'd23: atan_turn = 32'd81;
			5'd24: atan_turn = 32'd41;        5'd25: atan_turn = 32'd20;
			5'd26: atan_turn = 32'd10;        5'd27: atan_turn = 32'd5;
			5'd28: atan_turn = 32'd3;         5'd29: atan_turn = 32'd1;
			default: atan_turn = 32'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

FILE: rtl/fcp_stream_if.sv
// valid/ready channel carrying one payload type
// depends on nothing
`default_nettype none
interface fcp_stream_if #(parameter type payload_t = logic) (input wire logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/fly_camera_pose_update.sv
// fly camera pose update top level
// depends on fcp_pkg, fcp_stream_if, fcp_ctrl, fcp_datapath
//
//  channel  dir  payload
//  in_ch    in   pitch/yaw deltas, three step lengths
//  out_ch   out  location, forward, up, right vectors
//
// from request to result: the accepting edge loads the angles, then come the
// pitch cordic, the yaw cordic, the vector products and the location
// accumulates; the accumulates and some vector products use the shared multiplier
// the result register holds until taken; the next request waits for it, so
// a new request is not accepted while one is in progress or still pending
// arst_n clears angles, location and control
`default_nettype none
module fly_camera_pose_update #(
	parameter int ANGLE_BITS    = fcp_pkg::ANGLE_BITS_DEF,
	parameter int VEC_FRAC_BITS = fcp_pkg::VEC_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	fcp_stream_if.sink   in_ch,
	fcp_stream_if.source out_ch
);
	import fcp_pkg::*;
	dp_cmd_t cmd;
	// controller owns the handshake
	fcp_ctrl u_ctrl (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd);
	// datapath holds angles, location and the cordic registers
	fcp_datapath #(.ANGLE_BITS(ANGLE_BITS), .VEC_FRAC_BITS(VEC_FRAC_BITS)) u_dp (
		.clk, .arst_n, .cmd, .in_data(in_ch.data), .out_data(out_ch.data));
endmodule
`default_nettype wire

FILE: rtl/fcp_ctrl.sv
// sequencer for the pose update: issues datapath commands per item
// depends on fcp_pkg
`default_nettype none
module fcp_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output fcp_pkg::dp_cmd_t     cmd
);
	import fcp_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0, S_CP = 3'd1, S_CY = 3'd2, S_MUL = 3'd3,
		S_MAC = 3'd4;
	logic [2:0] state_q;
	logic [4:0] cnt_q;
	logic       full_q;
	logic       start;
	logic       done;

	assign in_ready  = (state_q == S_IDLE) && !full_q;
	assign out_valid = full_q;
	assign start     = in_valid && in_ready;

	always_comb begin
		cmd.op = OP_NONE;
		cmd.step = cnt_q;
		done = 1'b0;
		case (state_q)
			S_IDLE: if (start) cmd.op = OP_LOAD;
			S_CP: cmd.op = (cnt_q == 5'd0) ? OP_CINITP :
				(cnt_q == 5'd31) ? OP_CENDP : OP_CSTEP;
			S_CY: cmd.op = (cnt_q == 5'd0) ? OP_CINITY :
				(cnt_q == 5'd31) ? OP_CENDY : OP_CSTEP;
			S_MUL: cmd.op = OP_MUL;
			S_MAC: begin
				cmd.op = OP_MACC;
				done = (cnt_q == 5'd8);
			end
			default: cmd.op = OP_NONE;
		endcase
		// cordic steps use index cnt-1
		if (state_q == S_CP || state_q == S_CY) cmd.step = cnt_q - 5'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			full_q <= 1'b0;
		end else begin
			if (full_q && out_ready) full_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_CP;
					cnt_q <= '0;
				end
				S_CP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= S_CY;
				end
				S_CY: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= S_MUL;
						cnt_q <= '0;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd3) begin
						state_q <= S_MAC;
						cnt_q <= '0;
					end
				end
				S_MAC: begin
					cnt_q <= cnt_q + 5'd1;
					if (done) begin
						state_q <= S_IDLE;
						full_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/fcp_datapath.sv
// cordic unit, vector products and location accumulate
// depends on fcp_pkg
`default_nettype none
module fcp_datapath #(
	parameter int ANGLE_BITS    = fcp_pkg::ANGLE_BITS_DEF,
	parameter int VEC_FRAC_BITS = fcp_pkg::VEC_FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fcp_pkg::dp_cmd_t cmd,
	input  wire fcp_pkg::in_req_t in_data,
	output fcp_pkg::out_req_t     out_data
);
	import fcp_pkg::*;
	localparam int AB = ANGLE_BITS;
	localparam int VF = VEC_FRAC_BITS;
	// vector component width, holds plus or minus one and its negation
	localparam int VW = VF + 2;
	// pitch sum width, covers the 16-bit delta and the stored angle
	localparam int PW = ((AB > 16) ? AB : 16) + 1;
	localparam logic signed [PW-1:0] PLIM =
		PW'((64'd1 << AB) * 64'd157070000 / 64'd628318531);
	localparam logic signed [VW-1:0] VONE = VW'(1) << VF;
	localparam int RS = 30 - VF;

	logic signed [AB-1:0] pitch_q, yaw_q;
	logic signed [31:0]   loc_q [3];
	logic signed [31:0]   mr_q, mu_q, mf_q;
	logic signed [33:0]   cx_q, cy_q;
	logic signed [33:0]   cz_q;
	logic [1:0]           k_q;
	logic signed [VW-1:0] sp_q, cp_q, sy_q, cyw_q;
	logic signed [VW-1:0] fwd_q [3];
	logic signed [VW-1:0] up_q [3];
	logic signed [2*VW-1:0] t0_q;

	// pitch sum and clamp
	logic signed [PW-1:0] psum;
	logic signed [AB-1:0] pnext;
	always_comb begin
		psum = PW'(pitch_q) + PW'($signed(in_data.pitch_delta));
		if (psum > PLIM) psum = PLIM;
		if (psum < -PLIM) psum = -PLIM;
		pnext = psum[AB-1:0];
	end

	function automatic logic signed [VW-1:0] clampu(input logic signed [63:0] v);
		if (v > 64'(VONE)) return VONE;
		if (v < -64'(VONE)) return -VONE;
		return VW'(v);
	endfunction

	function automatic logic signed [VW-1:0] rnd(input logic signed [63:0] v, input int n);
		return clampu((v + (64'sd1 <<< (n-1))) >>> n);
	endfunction

	// cordic init from angle
	logic [31:0] ang, uu;
	logic [1:0]  kk;
	always_comb begin
		ang = (cmd.op == OP_CINITP) ? {pitch_q, {(32-AB){1'b0}}} : {yaw_q, {(32-AB){1'b0}}};
		kk = 2'((ang + 32'h20000000) >> 30);
		uu = ang - {kk, 30'd0};
	end

	logic signed [VW-1:0] cr, sr, cq, sq;
	always_comb begin
		cr = rnd(64'(cx_q), RS);
		sr = rnd(64'(cy_q), RS);
		case (k_q)
			2'd0: begin cq = cr; sq = sr; end
			2'd1: begin cq = -sr; sq = cr; end
			2'd2: begin cq = -cr; sq = -sr; end
			default: begin cq = sr; sq = -cr; end
		endcase
	end

	// shared multiplier operands
	logic signed [VW-1:0] ma;
	logic signed [31:0] mb;
	logic signed [3:0]  sel;
	always_comb begin
		ma = '0; mb = '0;
		case (cmd.op)
			OP_MUL: case (cmd.step[1:0])
				2'd0: begin ma = sy_q; mb = 32'(cp_q); end
				2'd1: begin ma = cp_q; mb = 32'(cyw_q); end
				2'd2: begin ma = fwd_q[1]; mb = 32'(sy_q); end
				default: begin ma = fwd_q[0]; mb = 32'(sy_q); end
			endcase
			OP_MACC: case (cmd.step)
				5'd0: begin ma = -cyw_q; mb = mr_q; end
				5'd1: begin ma = '0; mb = mr_q; end
				5'd2: begin ma = sy_q; mb = mr_q; end
				5'd3: begin ma = up_q[0]; mb = mu_q; end
				5'd4: begin ma = up_q[1]; mb = mu_q; end
				5'd5: begin ma = up_q[2]; mb = mu_q; end
				5'd6: begin ma = fwd_q[0]; mb = mf_q; end
				5'd7: begin ma = fwd_q[1]; mb = mf_q; end
				default: begin ma = fwd_q[2]; mb = mf_q; end
			endcase
			default: ;
		endcase
	end
	assign sel = '0;
	logic signed [VW+31:0] mp;
	assign mp = (VW+32)'(ma) * (VW+32)'(mb) + (VW+32)'(sel);

	logic signed [33:0] len;
	logic [1:0] li;
	logic signed [33:0] lsum;
	always_comb begin
		len = 34'((64'(mp) + (64'sd1 <<< (VF-1))) >>> VF);
		li = (cmd.step == 5'd0 || cmd.step == 5'd3 || cmd.step == 5'd6) ? 2'd0 :
			(cmd.step == 5'd1 || cmd.step == 5'd4 || cmd.step == 5'd7) ? 2'd1 : 2'd2;
		lsum = 34'(loc_q[li]) + len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0; yaw_q <= '0;
			loc_q[0] <= '0; loc_q[1] <= '0; loc_q[2] <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					pitch_q <= pnext;
					yaw_q <= yaw_q + AB'($signed(in_data.yaw_delta));
				end
				OP_MACC: begin
					if (lsum > 34'sd2147483647) loc_q[li] <= 32'sh7fffffff;
					else if (lsum < -34'sd2147483648) loc_q[li] <= 32'sh80000000;
					else loc_q[li] <= lsum[31:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mr_q <= in_data.move_right;
				mu_q <= in_data.move_up;
				mf_q <= in_data.move_forward;
			end
			OP_CINITP, OP_CINITY: begin
				cx_q <= 34'(CORDIC_GAIN_Q30); cy_q <= '0;
				cz_q <= 34'($signed(uu)); k_q <= kk;
			end
			OP_CSTEP: begin
				if (cz_q >= 0) begin
					cx_q <= cx_q - (cy_q >>> cmd.step);
					cy_q <= cy_q + (cx_q >>> cmd.step);
					cz_q <= cz_q - 34'(atan_turn(cmd.step));
				end else begin
					cx_q <= cx_q + (cy_q >>> cmd.step);
					cy_q <= cy_q - (cx_q >>> cmd.step);
					cz_q <= cz_q + 34'(atan_turn(cmd.step));
				end
			end
			OP_CENDP: begin sp_q <= sq; cp_q <= cq; end
			OP_CENDY: begin sy_q <= sq; cyw_q <= cq; end
			OP_MUL: case (cmd.step[1:0])
				2'd0: begin fwd_q[0] <= -rnd(64'(mp), VF); fwd_q[1] <= -sp_q; end
				2'd1: fwd_q[2] <= -rnd(64'(mp), VF);
				2'd2: begin
					up_q[0] <= rnd(64'(mp), VF);
					up_q[2] <= rnd(64'(fwd_q[1]) * 64'(cyw_q), VF);
					t0_q <= (2*VW)'(64'(-fwd_q[2]) * 64'(cyw_q));
				end
				default: up_q[1] <= rnd(64'(t0_q) - 64'(mp), VF);
			endcase
			default: ;
		endcase
	end

	assign out_data.pos_x = loc_q[0];
	assign out_data.pos_y = loc_q[1];
	assign out_data.pos_z = loc_q[2];
	assign out_data.fwd_x = 16'(fwd_q[0]);
	assign out_data.fwd_y = 16'(fwd_q[1]);
	assign out_data.fwd_z = 16'(fwd_q[2]);
	assign out_data.up_x = 16'(up_q[0]);
	assign out_data.up_y = 16'(up_q[1]);
	assign out_data.up_z = 16'(up_q[2]);
	assign out_data.right_x = 16'(-cyw_q);
	assign out_data.right_z = 16'(sy_q);
endmodule
`default_nettype wire

FILE: rtl/fcp_checker.sv
// port-level checker for the fly camera pose update, bound to the top
// depends on fly_camera_pose_update_defines.svh
`default_nettype none
`include "fly_camera_pose_update_defines.svh"
module fcp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);
	`FCP_ASSERT(a_no_in_while_full, clk, arst_n, out_valid |-> !in_ready, "input taken while result pending")
	`FCP_ASSERT(a_result_after_request, clk, arst_n, (in_valid && in_ready) |=> !out_valid, "result too soon")
	`FCP_ASSERT(a_out_holds, clk, arst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
	`FCP_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !out_valid, "result valid after reset")
endmodule
bind fly_camera_pose_update fcp_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready));
`default_nettype wire

FILE: tb/fcp_pose_checker.sv
// pose checker: watches both channels, predicts each camera pose and compares it
// depends on fcp_pkg and fcp_stream_if
`timescale 1ns / 1ps
`default_nettype none
module fcp_pose_checker (
	input wire logic clk,
	input wire logic arst_n,
	fcp_stream_if.sink in_mon,
	fcp_stream_if.sink out_mon,
	output int fail_count,
	output int pending_poses,
	output int poses_seen
);
	import fcp_pkg::*;

	localparam longint VEC_ONE = 64'sd16384;
	localparam longint PITCH_LIMIT = (longint'(65536) * 157070000) / 628318531;

	longint loc_x, loc_y, loc_z;
	longint pitch_acc;
	longint yaw_acc;
	out_req_t expected_poses[$];

	function automatic longint fdiv(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint rnd(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint unit_clip(longint v);
		if (v > VEC_ONE) return VEC_ONE;
		if (v < -VEC_ONE) return -VEC_ONE;
		return v;
	endfunction

	function automatic longint sat_loc(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// quadrant fold, then rotation from the gain-compensated start
	task automatic rotate(input logic [31:0] a, output longint sn, output longint cs);
		logic [31:0] k, u;
		longint z, x, y, nx, c, s;
		k = ((a + 32'h2000_0000) >> 30) & 32'd3;
		u = a - (k << 30);
		z = longint'($signed(u));
		x = CORDIC_GAIN_Q30;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - fdiv(y, i);
				y = y + fdiv(x, i);
				z -= longint'(atan_turn(5'(i)));
			end else begin
				nx = x + fdiv(y, i);
				y = y - fdiv(x, i);
				z += longint'(atan_turn(5'(i)));
			end
			x = nx;
		end
		c = unit_clip(rnd(x, 16));
		s = unit_clip(rnd(y, 16));
		case (k)
			0: begin cs = c; sn = s; end
			1: begin cs = -s; sn = c; end
			2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endtask

	task automatic predict_pose(input in_req_t r);
		longint p, sp, cp, sy, cy, rx, rz, fx, fy, fz, ux, uy, uz;
		longint mr, mu, mf;
		out_req_t o;
		p = pitch_acc + longint'($signed(r.pitch_delta));
		if (p > PITCH_LIMIT) p = PITCH_LIMIT;
		if (p < -PITCH_LIMIT) p = -PITCH_LIMIT;
		pitch_acc = p;
		yaw_acc = (yaw_acc + longint'($signed(r.yaw_delta))) & 64'hFFFF;
		rotate({p[15:0], 16'h0}, sp, cp);
		rotate({yaw_acc[15:0], 16'h0}, sy, cy);
		rx = -cy;
		rz = sy;
		fx = -unit_clip(rnd(sy * cp, 14));
		fy = -sp;
		fz = -unit_clip(rnd(cp * cy, 14));
		ux = unit_clip(rnd(fy * rz, 14));
		uy = unit_clip(rnd(fz * rx - fx * rz, 14));
		uz = unit_clip(rnd(-(fy * rx), 14));
		mr = longint'($signed(r.move_right));
		mu = longint'($signed(r.move_up));
		mf = longint'($signed(r.move_forward));
		// right has no y part; adds saturate one vector at a time
		loc_x = sat_loc(loc_x + rnd(rx * mr, 14));
		loc_z = sat_loc(loc_z + rnd(rz * mr, 14));
		loc_x = sat_loc(loc_x + rnd(ux * mu, 14));
		loc_y = sat_loc(loc_y + rnd(uy * mu, 14));
		loc_z = sat_loc(loc_z + rnd(uz * mu, 14));
		loc_x = sat_loc(loc_x + rnd(fx * mf, 14));
		loc_y = sat_loc(loc_y + rnd(fy * mf, 14));
		loc_z = sat_loc(loc_z + rnd(fz * mf, 14));
		o.pos_x = loc_x[31:0];
		o.pos_y = loc_y[31:0];
		o.pos_z = loc_z[31:0];
		o.fwd_x = fx[15:0];
		o.fwd_y = fy[15:0];
		o.fwd_z = fz[15:0];
		o.up_x = ux[15:0];
		o.up_y = uy[15:0];
		o.up_z = uz[15:0];
		o.right_x = rx[15:0];
		o.right_z = rz[15:0];
		expected_poses.push_back(o);
	endtask

	task automatic flag(input string what, input out_req_t exp_p, input out_req_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("pose mismatch (%s): expected %h got %h", what, exp_p, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_req_t e, g;
		if (!arst_n) begin
			loc_x = 0; loc_y = 0; loc_z = 0;
			pitch_acc = 0; yaw_acc = 0;
			expected_poses.delete();
			fail_count = 0;
			poses_seen <= 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				g = out_mon.data;
				poses_seen <= poses_seen + 1;
				if (expected_poses.size() == 0) begin
					e = '0;
					flag("unexpected", e, g);
				end else begin
					e = expected_poses.pop_front();
					if (g.pos_x !== e.pos_x) flag("pos_x", e, g);
					if (g.pos_y !== e.pos_y) flag("pos_y", e, g);
					if (g.pos_z !== e.pos_z) flag("pos_z", e, g);
					if (g.fwd_x !== e.fwd_x) flag("fwd_x", e, g);
					if (g.fwd_y !== e.fwd_y) flag("fwd_y", e, g);
					if (g.fwd_z !== e.fwd_z) flag("fwd_z", e, g);
					if (g.up_x !== e.up_x) flag("up_x", e, g);
					if (g.up_y !== e.up_y) flag("up_y", e, g);
					if (g.up_z !== e.up_z) flag("up_z", e, g);
					if (g.right_x !== e.right_x) flag("right_x", e, g);
					if (g.right_z !== e.right_z) flag("right_z", e, g);
				end
			end
			if (in_mon.valid && in_mon.ready)
				predict_pose(in_mon.data);
		end
		pending_poses <= expected_poses.size();
	end
endmodule
`default_nettype wire

FILE: tb/fly_camera_pose_update_tb.sv
// testbench top for the fly camera pose update: clock, reset, stimulus, verdict
// depends on fcp_pkg, fcp_stream_if, fcp_pose_checker and the block itself
`timescale 1ns / 1ps
`default_nettype none
module fly_camera_pose_update_tb;
	import fcp_pkg::*;

	localparam int RANDOM_REQUESTS = 1430;
	localparam int LAST_QUIET = 150;       // final requests sent with no idling
	localparam int LONG_HOLD = 400;        // receiver hold-off in cycles
	localparam int STALL_LIMIT = 3000;     // cycles with no handshake before giving up

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending_poses, poses_seen;
	int requests_sent = 0;
	int idle_cycles = 0;
	bit quiet_phase = 1'b0;
	bit hold_request = 1'b0;

	always #10 clk = ~clk;

	fcp_stream_if #(.payload_t(in_req_t))  in_ch (clk);
	fcp_stream_if #(.payload_t(out_req_t)) out_ch (clk);

	fly_camera_pose_update DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	fcp_pose_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.fail_count(fail_count),
		.pending_poses(pending_poses),
		.poses_seen(poses_seen)
	);

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	// random step length: mostly small steps, sometimes full range to hit saturation
	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 9))
			0, 1: return $urandom();
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return 32'd0;
			default: return 32'($signed(16'($urandom())) * 4);
		endcase
	endfunction

	// pitch deltas are mostly small, sometimes extreme to push against the clamp; yaw deltas wrap freely
	function automatic in_req_t pick_request();
		in_req_t r;
		case ($urandom_range(0, 5))
			0: r.pitch_delta = $urandom();
			1: r.pitch_delta = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: r.pitch_delta = 16'($signed(12'($urandom())));
		endcase
		r.yaw_delta = $urandom_range(0, 2) == 0 ? 16'($urandom())
			: 16'($signed(12'($urandom())));
		r.move_right = pick_step();
		r.move_up = pick_step();
		r.move_forward = pick_step();
		return r;
	endfunction

	// offer one request and hold it until the block takes it
	// valid stays high between back-to-back requests and drops only for idling
	task automatic send_request(input in_req_t r);
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= r;
		do @(posedge clk); while (!in_ch.ready);
		requests_sent++;
	endtask

	task automatic send_fields(input logic [15:0] pd, input logic [15:0] yd,
			input logic [31:0] mr, input logic [31:0] mu, input logic [31:0] mf);
		in_req_t r;
		r.pitch_delta = pd;
		r.yaw_delta = yd;
		r.move_right = mr;
		r.move_up = mu;
		r.move_forward = mf;
		send_request(r);
	endtask

	// receiver: random stalls, one long hold-off, steady ready at the end
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of each field, clamp on both sides, yaw wrap, saturation
		send_fields(16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
		send_fields(16'h7FFF, 16'h0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_fields(16'h7FFF, 16'h4000, 32'h0, 32'h0, 32'h7FFF_FFFF);
		send_fields(16'h8000, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_fields(16'h8000, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_fields(16'h4000, 16'h7FFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_fields(16'h0001, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_fields(16'hFFFF, 16'h2000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000);
		send_fields(16'hC000, 16'hE000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_5555);
		send_fields(16'h2000, 16'h1000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h55AA_55AA);
		send_fields(16'hE000, 16'hC000, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000);
		send_fields(16'h5555, 16'hAAAA, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
		send_fields(16'hAAAA, 16'h5555, 32'hFEDC_BA98, 32'h0F0F_0F0F, 32'hF0F0_F0F0);

		// one long receiver hold-off while requests keep coming
		hold_request = 1'b1;
		repeat (8) send_request(pick_request());

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == RANDOM_REQUESTS - LAST_QUIET)
				quiet_phase = 1'b1;
			send_request(pick_request());
		end
		in_ch.valid <= 1'b0;

		while (pending_poses != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d pose requests, %0d poses returned", requests_sent, poses_seen);
		$display("covered pitch clamp, yaw wrap, location saturation and stalls on both sides");
		if (fail_count == 0 && pending_poses == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
